/* src/history_q_learning_engine_core_defines.svh */
// Assertion macros for the history Q-learning engine.
`ifndef HISTORY_Q_LEARNING_ENGINE_CORE_DEFINES_SVH
`define HISTORY_Q_LEARNING_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HQLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HQLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hqle_pkg.sv */
// Shared types, codes and constants of the history Q-learning engine.
`timescale 1ns / 1ps
package hqle_pkg;

    localparam int OBS_COUNT_DEF     = 12;
    localparam int ACTION_COUNT_DEF  = 7;
    localparam int HISTORY_STEPS_DEF = 1;
    localparam int TABLE_DEPTH_DEF   = OBS_COUNT_DEF * OBS_COUNT_DEF * ACTION_COUNT_DEF
                                       * ACTION_COUNT_DEF;

    localparam int Q_W      = 32;
    localparam int RATE_W   = 16;
    localparam int EPLEN_W  = 7;
    localparam int ENT_W    = 4;
    localparam int ACT_IN_W = 3;
    localparam int ROW_IN_W = 10;
    localparam int STEP_W   = 6;
    localparam int CFG_W    = 16;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 40;

    // input tdata layout
    localparam int IN_ACT_LO  = 0;
    localparam int IN_OBS_LO  = 3;
    localparam int IN_REW_LO  = 7;
    localparam int IN_ROW_LO  = 39;
    localparam int IN_LVAL_LO = 49;

    localparam logic [RATE_W-1:0]  DISCOUNT_RST = 16'd62259;
    localparam logic [RATE_W-1:0]  LEARN_RST    = 16'd55706;
    localparam logic [EPLEN_W-1:0] EPLEN_RST    = 7'd20;
    localparam logic [ENT_W-1:0]   INIT_OBS_RST = 4'd0;
    localparam logic [EPLEN_W-1:0] EPLEN_MIN    = 7'd2;
    localparam logic [EPLEN_W-1:0] EPLEN_MAX    = 7'd64;

    localparam logic [1:0] REG_DISCOUNT = 2'd0;
    localparam logic [1:0] REG_LEARN    = 2'd1;
    localparam logic [1:0] REG_EPLEN    = 2'd2;
    localparam logic [1:0] REG_INIT_OBS = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READQ,
        S_SCAN,
        S_CALC,
        S_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic              term;
        logic [Q_W-1:0]    reward;
        logic [Q_W-1:0]    maxq;
        logic [Q_W-1:0]    q;
        logic [RATE_W-1:0] discount;
        logic [RATE_W-1:0] learn;
    } t_arith_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] value;
    } t_arith_rsp;

endpackage

/* src/hqle_table.sv */
// Value table: single-port-write, registered-read synchronous memory.
`timescale 1ns / 1ps
module hqle_table
    import hqle_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = Q_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/hqle_arith.sv */
// Six-stage update datapath: rounded target, difference, scaled gap, saturation.
`timescale 1ns / 1ps
module hqle_arith
    import hqle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_arith_req i_req,
    output t_arith_rsp o_rsp
);

    logic [5:0]            r_vld;
    t_arith_req            r_req;
    logic signed [48:0]    r_p1;
    logic signed [49:0]    r_tgt;
    logic signed [34:0]    r_diff;
    logic signed [51:0]    r_p2;
    logic signed [35:0]    r_gap;
    logic [Q_W-1:0]        r_res;

    logic signed [34:0]    diff_term;
    logic signed [34:0]    diff_step;
    logic signed [51:0]    p2_rnd;
    logic signed [36:0]    sum;

    always_comb begin
        diff_term = $signed({{3{r_req.reward[Q_W-1]}}, r_req.reward})
                  - $signed({{3{r_req.q[Q_W-1]}}, r_req.q});
        diff_step = $signed({r_tgt[49], r_tgt[49:16]})
                  - $signed({{3{r_req.q[Q_W-1]}}, r_req.q});
        p2_rnd    = r_p2 + 52'sh8000;
        sum       = $signed({{5{r_req.q[Q_W-1]}}, r_req.q}) + $signed({r_gap[35], r_gap});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_req.start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_req <= i_req;
            r_p1  <= $signed({1'b0, i_req.discount}) * $signed(i_req.maxq);
        end
        if (r_vld[0]) begin
            // low half of reward*2^16 is zero, so the rounding constant drops in there
            r_tgt <= $signed({{2{r_req.reward[Q_W-1]}}, r_req.reward, 16'h8000})
                   + $signed({r_p1[48], r_p1});
        end
        if (r_vld[1]) begin
            r_diff <= r_req.term ? diff_term : diff_step;
        end
        if (r_vld[2]) begin
            r_p2 <= $signed({1'b0, r_req.learn}) * r_diff;
        end
        if (r_vld[3]) begin
            r_gap <= p2_rnd[51:16];
        end
        if (r_vld[4]) begin
            if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
                r_res <= sum[31:0];
            end else if (sum[36]) begin
                r_res <= 32'h8000_0000;
            end else begin
                r_res <= 32'h7FFF_FFFF;
            end
        end
    end

    assign o_rsp.done  = r_vld[5];
    assign o_rsp.value = r_res;

endmodule

/* src/history_q_learning_engine_core.sv */
// Top level: command sequencer, history window and value-table access.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+----------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tuser command, tdata request fields
//  m_axis    | out | m_axis_tvalid/tready    | tdata result, tuser history_full, tlast
//  cfg       | in  | i_cfg_wr_en             | i_cfg_idx, i_cfg_wdata
//
// One request at a time. Load, start and unused commands: one row scan of ACTION_COUNT
// reads on the single table read port, then the result.
// Transition with update: one read of Q, a max scan of the new row (skipped on a
// terminal step), 6 arithmetic stages, the write, and a second row scan when the
// written row is the reported row.
// Reset is synchronous; the table is not cleared. A result waiting on m_axis
// does not block the next request, only the delivery of the one after it.
`timescale 1ns / 1ps
`include "history_q_learning_engine_core_defines.svh"
module history_q_learning_engine_core
    import hqle_pkg::*;
#(
    parameter int OBS_COUNT     = OBS_COUNT_DEF,
    parameter int ACTION_COUNT  = ACTION_COUNT_DEF,
    parameter int HISTORY_STEPS = HISTORY_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // action[2:0], observation[6:3], reward[38:7], table_row[48:39], load_value[80:49]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // greedy_action[2:0], updated_value[34:3]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // history_full[0]
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int WIN_LEN   = 2 * HISTORY_STEPS + 1;
    localparam int ROW_COUNT = (OBS_COUNT ** (HISTORY_STEPS + 1))
                               * (ACTION_COUNT ** HISTORY_STEPS);
    localparam int DEPTH     = ROW_COUNT * ACTION_COUNT;
    localparam int AW        = $clog2(DEPTH);
    localparam int RW        = $clog2(ROW_COUNT);
    localparam int CW        = $clog2(ACTION_COUNT + 1);
    localparam int AIW       = $clog2(ACTION_COUNT);
    localparam logic [AW-1:0]    ACT_AW  = AW'(ACTION_COUNT);
    localparam logic [ENT_W-1:0] ACT_MAX = ENT_W'(ACTION_COUNT - 1);
    localparam logic [ENT_W-1:0] OBS_MAX = ENT_W'(OBS_COUNT - 1);

    typedef logic [WIN_LEN-1:0][ENT_W-1:0] t_window;

    // mixed-radix row code, last observation is the lowest digit
    function automatic logic [RW-1:0] f_row(input t_window win);
        logic [RW-1:0] total;
        total = RW'(win[0]);
        for (int i = 1; i < WIN_LEN; i++) begin
            total = total * RW'((i % 2 == 1) ? ACTION_COUNT : OBS_COUNT) + RW'(win[i]);
        end
        return total;
    endfunction

    t_state             r_state;
    t_state             n_state;

    logic [RATE_W-1:0]  r_discount;
    logic [RATE_W-1:0]  r_learn;
    logic [EPLEN_W-1:0] r_eplen;
    logic [ENT_W-1:0]   r_init_obs;

    t_window            r_window;
    t_window            n_window;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    logic [RW-1:0]      r_row;
    logic [RW-1:0]      r_old_row;

    logic [AW-1:0]      r_idx;
    logic [Q_W-1:0]     r_reward;
    logic [Q_W-1:0]     r_q;
    logic [Q_W-1:0]     r_upd;
    logic               r_term;
    logic               r_full;
    logic               r_done;

    logic [CW-1:0]      r_scan_cnt;
    logic               r_scan_pend;
    logic [AIW-1:0]     r_scan_act;
    logic               r_scan_max;
    logic signed [Q_W-1:0] r_best_val;
    logic [AIW-1:0]     r_best_act;

    logic               r_out_valid;
    logic [2:0]         r_out_greedy;
    logic [Q_W-1:0]     r_out_upd;
    logic               r_out_full;
    logic               r_out_done;

    // request fields
    t_cmd               in_cmd;
    logic [ACT_IN_W-1:0] in_act;
    logic [ENT_W-1:0]   in_obs;
    logic [Q_W-1:0]     in_reward;
    logic [ROW_IN_W-1:0] in_trow;
    logic [Q_W-1:0]     in_lval;

    logic [ENT_W-1:0]   act_sat;
    logic [ENT_W-1:0]   obs_sat;
    logic [ENT_W-1:0]   init_sat;
    logic [EPLEN_W-1:0] len_c;
    logic [STEP_W-1:0]  step_last;
    logic               step_done;
    logic               step_fill;
    logic               load_ok;
    logic               accept;
    logic               out_load;

    logic [AW-1:0]      row_base;
    logic [AW-1:0]      scan_addr;
    logic [AW-1:0]      step_addr;
    logic [AW-1:0]      load_addr;
    logic               scan_issue;
    logic               scan_last;
    logic               scan_take;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [Q_W-1:0]     mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [Q_W-1:0]     mem_rdata;

    t_arith_req         arith_req;
    t_arith_rsp         arith_rsp;

    assign in_cmd    = t_cmd'(s_axis_tuser);
    assign in_act    = s_axis_tdata[IN_ACT_LO +: ACT_IN_W];
    assign in_obs    = s_axis_tdata[IN_OBS_LO +: ENT_W];
    assign in_reward = s_axis_tdata[IN_REW_LO +: Q_W];
    assign in_trow   = s_axis_tdata[IN_ROW_LO +: ROW_IN_W];
    assign in_lval   = s_axis_tdata[IN_LVAL_LO +: Q_W];

    assign act_sat  = (32'(in_act) > ACTION_COUNT - 1) ? ACT_MAX : ENT_W'(in_act);
    assign obs_sat  = (32'(in_obs) > OBS_COUNT - 1) ? OBS_MAX : in_obs;
    assign init_sat = (32'(r_init_obs) > OBS_COUNT - 1) ? OBS_MAX : r_init_obs;
    assign len_c    = (r_eplen < EPLEN_MIN) ? EPLEN_MIN :
                      (r_eplen > EPLEN_MAX) ? EPLEN_MAX : r_eplen;
    assign step_last = STEP_W'(len_c - 7'd1);
    assign step_done = (r_step >= step_last);
    assign step_fill = (32'(r_step) < HISTORY_STEPS);
    assign load_ok   = (32'(in_trow) < ROW_COUNT) && (32'(in_act) < ACTION_COUNT);

    assign row_base  = AW'(r_row) * ACT_AW;
    assign scan_addr = row_base + AW'(r_scan_cnt);
    assign step_addr = row_base + AW'(act_sat);
    assign load_addr = AW'(in_trow) * ACT_AW + AW'(in_act);

    assign scan_issue = (r_state == S_SCAN) && (32'(r_scan_cnt) < ACTION_COUNT);
    assign scan_last  = r_scan_pend && (32'(r_scan_act) == ACTION_COUNT - 1);
    assign scan_take  = r_scan_pend
                        && ((r_scan_act == '0) || ($signed(mem_rdata) > r_best_val));

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_window  = r_window;
        n_step    = r_step;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = arith_rsp.value;
        mem_raddr = scan_addr;
        out_load  = 1'b0;
        arith_req.start    = (r_state == S_CALC);
        arith_req.term     = r_term;
        arith_req.reward   = r_reward;
        arith_req.maxq     = r_best_val;
        arith_req.q        = r_q;
        arith_req.discount = r_discount;
        arith_req.learn    = r_learn;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    case (in_cmd)
                        CMD_LOAD: begin
                            mem_we    = load_ok;
                            mem_waddr = load_addr;
                            mem_wdata = in_lval;
                        end
                        CMD_START: begin
                            n_window    = '0;
                            n_window[0] = init_sat;
                            n_step      = '0;
                        end
                        CMD_STEP: begin
                            n_step = step_done ? step_last : r_step + 1'b1;
                            if (step_fill) begin
                                for (int i = 0; i < WIN_LEN; i++) begin
                                    if (i == 2 * int'(r_step) + 1) begin
                                        n_window[i] = act_sat;
                                    end
                                    if (!step_done && i == 2 * int'(r_step) + 2) begin
                                        n_window[i] = obs_sat;
                                    end
                                end
                            end else begin
                                mem_raddr = step_addr;
                                n_state   = S_READQ;
                                if (!step_done) begin
                                    for (int i = 0; i < WIN_LEN - 2; i++) begin
                                        n_window[i] = r_window[i + 2];
                                    end
                                    for (int i = 0; i < WIN_LEN; i++) begin
                                        if (i == WIN_LEN - 2) begin
                                            n_window[i] = act_sat;
                                        end
                                    end
                                    n_window[WIN_LEN-1] = obs_sat;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READQ: begin
                n_state = r_term ? S_CALC : S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = r_scan_max ? S_CALC : S_OUT;
                end
            end
            S_CALC: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (arith_rsp.done) begin
                    mem_we = 1'b1;
                    // greedy of the new row is still valid when the write went elsewhere
                    n_state = (!r_term && r_old_row != r_row) ? S_OUT : S_SCAN;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discount  <= DISCOUNT_RST;
            r_learn     <= LEARN_RST;
            r_eplen     <= EPLEN_RST;
            r_init_obs  <= INIT_OBS_RST;
            r_window    <= '0;
            r_step      <= '0;
            r_row       <= '0;
            r_scan_cnt  <= '0;
            r_scan_pend <= 1'b0;
            r_scan_act  <= '0;
            r_scan_max  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_DISCOUNT: r_discount <= i_cfg_wdata;
                    REG_LEARN:    r_learn    <= i_cfg_wdata;
                    REG_EPLEN:    r_eplen    <= i_cfg_wdata[EPLEN_W-1:0];
                    REG_INIT_OBS: r_init_obs <= i_cfg_wdata[ENT_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_window <= n_window;
            r_step   <= n_step;
            r_row    <= f_row(n_window);

            if (r_state != S_SCAN) begin
                r_scan_cnt  <= '0;
                r_scan_pend <= 1'b0;
            end else begin
                r_scan_pend <= scan_issue;
                if (scan_issue) begin
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                    r_scan_act <= AIW'(r_scan_cnt);
                end
            end

            if (r_state == S_READQ) begin
                r_scan_max <= !r_term;
            end else if (accept || r_state == S_WAIT) begin
                r_scan_max <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_reward  <= in_reward;
            r_idx     <= step_addr;
            r_old_row <= r_row;
            r_term    <= step_done;
            r_full    <= (in_cmd == CMD_STEP) && !step_fill;
            r_done    <= (in_cmd == CMD_STEP) && step_done;
            r_upd     <= (in_cmd == CMD_LOAD && load_ok) ? in_lval : '0;
        end
        if (r_state == S_READQ) begin
            r_q <= mem_rdata;
        end
        if (scan_take) begin
            r_best_val <= $signed(mem_rdata);
            r_best_act <= r_scan_act;
        end
        if (r_state == S_WAIT && arith_rsp.done) begin
            r_upd <= arith_rsp.value;
        end
        if (out_load) begin
            r_out_greedy <= 3'(r_best_act);
            r_out_upd    <= r_upd;
            r_out_full   <= r_full;
            r_out_done   <= r_done;
        end
    end

    hqle_table #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (Q_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hqle_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arith_req),
        .o_rsp   (arith_rsp)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_upd, r_out_greedy};
    assign m_axis_tuser  = r_out_full;
    assign m_axis_tlast  = r_out_done;

    `HQLE_ASSERT_IMP(a_mem_write_state, i_clk, i_rst_n, mem_we, (r_state == S_IDLE) || (r_state == S_WAIT), "table write outside load or update")
    `HQLE_ASSERT_IMP(a_arith_done_wait, i_clk, i_rst_n, arith_rsp.done, r_state == S_WAIT, "update result arrived outside wait state")
    `HQLE_ASSERT_IMP(a_scan_index, i_clk, i_rst_n, r_scan_pend, 32'(r_scan_act) < ACTION_COUNT, "row scan index beyond action count")
    `HQLE_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE, "request accepted without leaving idle")

endmodule
